### rtl/arpc_pkg.sv
// arpc_pkg: shared types and constants for the ARP cache with next-hop selection.
// Holds the word structs, status codes, register indexes and the controller state type.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package arpc_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int ADDR_W      = 32;
    localparam int MAC_W       = 48;
    localparam int SLOT_W      = 4;
    localparam int CFG_IDX_W   = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBNET     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GATEWAY    = 2'd2;

    // Item modes
    localparam logic MODE_INSERT  = 1'b0;
    localparam logic MODE_RESOLVE = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_HIT       = 3'd0,
        ST_MISS      = 3'd1,
        ST_UPDATED   = 3'd2,
        ST_FILLED    = 3'd3,
        ST_OVERWROTE = 3'd4
    } t_status;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] address;
        logic [MAC_W-1:0]  hw_address;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        status;
        logic [MAC_W-1:0]  found_hw_address;
        logic [ADDR_W-1:0] hop_address;
        logic [SLOT_W-1:0] slot;
    } t_out_item;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_DECIDE,
        S_DONE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic compare;
        logic commit;
    } t_dp_cmd;

endpackage

`default_nettype wire

### rtl/arpc_ctrl.sv
// arpc_ctrl: sequencer for one cache operation (capture, compare, commit, report).
// Drives the datapath through t_dp_cmd; depends on arpc_pkg.
`default_nettype none

module arpc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    output logic                   o_done,
    output arpc_pkg::t_dp_cmd      o_cmd
);
    import arpc_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        busy          = 1'b1;
        o_done        = 1'b0;
        case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_MATCH;
                end
            end
            S_MATCH: begin
                o_cmd.compare = 1'b1;
                n_state       = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.commit = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                o_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // An accepted word always produces a result, through the MATCH and DECIDE states to DONE
    a_accept_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_done)
        else $error("accepted word did not complete in time");

    // Result strobe lasts one cycle and the block is free right after
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!o_done && !busy))
        else $error("result strobe not followed by idle");

    // No word is taken while one is in flight
    a_no_capture_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_cmd.capture)
        else $error("capture while busy");

endmodule

`default_nettype wire

### rtl/arpc_dp.sv
// arpc_dp: configuration registers, entry store with parallel compare, MAC memory
// and result registers. Commanded by arpc_ctrl; depends on arpc_pkg.
`default_nettype none

module arpc_dp #(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [arpc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [arpc_pkg::ADDR_W-1:0]    i_cfg_data,
    input  wire arpc_pkg::t_in_item             i_item,
    input  wire arpc_pkg::t_dp_cmd              i_cmd,
    output arpc_pkg::t_out_item                 o_result
);
    import arpc_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Configuration
    logic [ADDR_W-1:0] r_local;
    logic [ADDR_W-1:0] r_mask;
    logic [ADDR_W-1:0] r_gw;

    // Captured word
    logic              r_mode;
    logic [ADDR_W-1:0] r_key;
    logic [MAC_W-1:0]  r_mac_in;

    // Entry store: addresses and valid bits compared in parallel, MACs in memory
    logic [ADDR_W-1:0]  r_ip [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [MAC_W-1:0]   r_mac_mem [ENTRIES];

    logic [ENTRIES-1:0] r_match;
    logic [ENTRIES-1:0] r_free;

    // Result registers
    t_status           r_status;
    logic              r_found;
    logic [MAC_W-1:0]  r_rd_mac;
    logic [IDX_W-1:0]  r_slot;

    logic [ADDR_W-1:0] n_key;
    logic              hit_any;
    logic [IDX_W-1:0]  hit_idx;
    logic              free_any;
    logic [IDX_W-1:0]  free_idx;
    logic              wr_en;
    logic              wr_new;
    logic [IDX_W-1:0]  wr_idx;
    t_status           n_status;
    logic [IDX_W-1:0]  n_slot;
    logic [31:0]       slot_wide;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local <= '0;
            r_mask  <= '0;
            r_gw    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LOCAL_ADDR: r_local <= i_cfg_data;
                CFG_SUBNET:     r_mask  <= i_cfg_data;
                CFG_GATEWAY:    r_gw    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Lookup key: inserted address, or next hop after the on-link test
    always_comb begin
        if (i_item.mode == MODE_RESOLVE &&
            (i_item.address & r_mask) != (r_local & r_mask)) begin
            n_key = r_gw;
        end else begin
            n_key = i_item.address;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode   <= i_item.mode;
            r_key    <= n_key;
            r_mac_in <= i_item.hw_address;
        end
    end

    // Parallel compare against every entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.compare) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_match[i] <= r_valid[i] && (r_ip[i] == r_key);
            end
            r_free <= ~r_valid;
        end
    end

    // Lowest-index priority encoders
    always_comb begin
        hit_any  = |r_match;
        free_any = |r_free;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                hit_idx = IDX_W'(i);
            end
            if (r_free[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    // Decide write target and result
    always_comb begin
        wr_en    = 1'b0;
        wr_new   = 1'b0;
        wr_idx   = '0;
        n_status = ST_MISS;
        n_slot   = '0;
        if (r_mode == MODE_RESOLVE) begin
            if (hit_any) begin
                n_status = ST_HIT;
                n_slot   = hit_idx;
            end
        end else begin
            wr_en = 1'b1;
            if (hit_any) begin
                n_status = ST_UPDATED;
                wr_idx   = hit_idx;
            end else if (free_any) begin
                n_status = ST_FILLED;
                wr_new   = 1'b1;
                wr_idx   = free_idx;
            end else begin
                // full cache: slot 0 is replaced
                n_status = ST_OVERWROTE;
                wr_new   = 1'b1;
                wr_idx   = '0;
            end
            n_slot = wr_idx;
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.commit && wr_new) begin
            r_valid[wr_idx] <= 1'b1;
        end
    end

    // Entry addresses
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && wr_new) begin
            r_ip[wr_idx] <= r_key;
        end
    end

    // MAC memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (wr_en) begin
                r_mac_mem[wr_idx] <= r_mac_in;
            end
            r_rd_mac <= r_mac_mem[hit_idx];
        end
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status <= n_status;
            r_found  <= (r_mode == MODE_RESOLVE) && hit_any;
            r_slot   <= n_slot;
        end
    end

    assign slot_wide = 32'(r_slot);

    always_comb begin
        o_result.status           = r_status;
        o_result.found_hw_address = r_found ? r_rd_mac : '0;
        o_result.hop_address      = r_key;
        o_result.slot             = slot_wide[SLOT_W-1:0];
    end

    // At most one entry per address can match when written through this block
    a_match_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> $onehot0(r_match))
        else $error("duplicate address in cache");

    // A new entry only goes into a free slot unless the cache is full
    a_fill_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && wr_new && free_any) |-> r_free[wr_idx])
        else $error("fill targeted a valid entry");

    // Inserted entries stay valid
    a_valid_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && wr_new) |=> r_valid[$past(wr_idx)])
        else $error("written entry not marked valid");

endmodule

`default_nettype wire

### rtl/arp_cache_with_next_hop.sv
// ARP cache with next-hop selection: a fully associative table of ENTRIES slots mapping
// IPv4 to MAC addresses. A word is taken when start is high and busy is low; its single
// result appears on o_result with o_done high for one cycle, after the capture /
// compare-all / encode-and-write / report sequence; busy stays high until the block is
// idle again, so no new word is taken before the last one is reported. The receiver
// cannot stall the result, so it must sample o_result whenever o_done is high.
// Configuration writes (index 0 local address, 1 subnet mask, 2 gateway) belong to idle
// periods. All entries are invalid right after reset; no clearing pass is needed.
// Depends on arpc_pkg, arpc_ctrl and arpc_dp.
`default_nettype none

module arp_cache_with_next_hop #(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [arpc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [arpc_pkg::ADDR_W-1:0]    i_cfg_data,
    input  wire logic                           start,
    output logic                                busy,
    input  wire arpc_pkg::t_in_item             i_item,
    output logic                                o_done,
    output arpc_pkg::t_out_item                 o_result
);
    import arpc_pkg::*;

    t_dp_cmd cmd;

    arpc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    arpc_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_cmd      (cmd),
        .o_result   (o_result)
    );

endmodule

`default_nettype wire
